// ===== src/magic_header_frame_deframer_defines.svh =====
// Assertion macros for the magic header frame deframer.
// Used by the front, queue and back modules; relies on clk_i and rst_ni in scope.
`ifndef MAGIC_HEADER_FRAME_DEFRAMER_DEFINES_SVH
`define MAGIC_HEADER_FRAME_DEFRAMER_DEFINES_SVH

// Check a property at every clock edge outside reset.
`define MHFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define MHFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mhfd_pkg.sv =====
// Shared constants, types and helpers for the magic header frame deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mhfd_pkg;

  localparam int HDR_LEN    = 12;
  localparam int MAGIC_LEN  = 4;
  localparam int SCAN_SPAN  = HDR_LEN - MAGIC_LEN;
  localparam int MAX_SIDE   = 4096;
  localparam int SIDE_W     = 13;
  localparam int LEFT_W     = 25;
  localparam int FILL_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [SIDE_W-1:0] WIDTH_RST  = SIDE_W'(320);
  localparam logic [SIDE_W-1:0] HEIGHT_RST = SIDE_W'(240);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC  = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

  // One payload byte with its frame marks
  typedef struct packed {
    logic [7:0] pixel;
    logic       first;
    logic       last;
  } pix_entry_t;

  // Clamp a configured side into 1..MAX_SIDE
  function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    r = v;
    if (v == '0) r = SIDE_W'(1);
    else if (v > SIDE_W'(MAX_SIDE)) r = SIDE_W'(MAX_SIDE);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/mhfd_front.sv =====
// Front end: configuration registers, header hunt and payload classification.
// Depends on mhfd_pkg; pushes payload requests into the queue.
`timescale 1ns / 1ps
`default_nettype none
`include "magic_header_frame_deframer_defines.svh"

module mhfd_front import mhfd_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire logic [7:0]            in_byte_i,
  input  wire logic                  q_ready_i,
  output      logic                  q_push_o,
  output      pix_entry_t            q_entry_o
);

  logic [CFG_DATA_W-1:0] magic_q;
  logic [SIDE_W-1:0]     eff_w_q, eff_h_q;

  logic [7:0]        window_q [HDR_LEN];
  logic [7:0]        window_d [HDR_LEN];
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              in_payload_q, in_payload_d;
  logic              first_q, first_d;
  logic [LEFT_W-1:0] left_q, left_d;

  logic                accept;
  logic [FILL_W-1:0]   fill_inc;
  logic [7:0]          app [HDR_LEN];
  logic                hdr_done, dims_ok, last_byte;
  logic [31:0]         wid_field, hgt_field;
  logic [2*SIDE_W-1:0] prod_full;

  logic [7:0]        view [2*SCAN_SPAN];
  logic [FILL_W-1:0] view_len, skip, scan_fill;
  logic              hit [SCAN_SPAN];
  logic [7:0]        shifted [SCAN_SPAN];

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = in_payload_q ? q_ready_i : 1'b1;
  assign last_byte  = (left_q == LEFT_W'(1));

  // Configuration writes; sides are clamped as they are stored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= '0;
      eff_w_q <= WIDTH_RST;
      eff_h_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAGIC:  magic_q <= cfg_data_i;
        CFG_WIDTH:  eff_w_q <= eff_side(cfg_data_i[SIDE_W-1:0]);
        CFG_HEIGHT: eff_h_q <= eff_side(cfg_data_i[SIDE_W-1:0]);
        default: ;
      endcase
    end
  end

  // Append the incoming byte at the fill position
  assign fill_inc = fill_q + 1'b1;
  always_comb begin
    for (int i = 0; i < HDR_LEN; i++) begin
      app[i] = (FILL_W'(i) == fill_q) ? in_byte_i : window_q[i];
    end
  end

  // Header dimension check, little-endian fields
  assign hdr_done  = (fill_inc == FILL_W'(HDR_LEN));
  assign wid_field = {app[7], app[6], app[5], app[4]};
  assign hgt_field = {app[11], app[10], app[9], app[8]};
  assign dims_ok   = (wid_field == 32'(eff_w_q)) && (hgt_field == 32'(eff_h_q));
  assign prod_full = (2*SIDE_W)'(eff_w_q) * (2*SIDE_W)'(eff_h_q);

  // Pick the bytes to rescan: the tail after a rejected header, or the short prefix
  always_comb begin
    for (int j = 0; j < 2*SCAN_SPAN; j++) begin
      view[j] = '0;
    end
    for (int j = 0; j < SCAN_SPAN; j++) begin
      view[j] = hdr_done ? app[j + MAGIC_LEN] : app[j];
    end
    view_len = hdr_done ? FILL_W'(SCAN_SPAN) : fill_inc;
  end

  // Compare the magic prefix at every offset in parallel
  always_comb begin
    for (int k = 0; k < SCAN_SPAN; k++) begin
      hit[k] = (FILL_W'(k) < view_len);
      for (int i = 0; i < MAGIC_LEN; i++) begin
        if ((FILL_W'(k + i) < view_len) && (view[k + i] != magic_q[8*i +: 8])) begin
          hit[k] = 1'b0;
        end
      end
    end
  end

  // Take the earliest matching offset; drop everything when none matches
  always_comb begin
    skip = view_len;
    for (int k = SCAN_SPAN - 1; k >= 0; k--) begin
      if (hit[k]) skip = FILL_W'(k);
    end
    scan_fill = view_len - skip;
    for (int j = 0; j < SCAN_SPAN; j++) begin
      shifted[j] = view[FILL_W'(j) + skip];
    end
  end

  // Next state and queue request
  always_comb begin
    fill_d       = fill_q;
    in_payload_d = in_payload_q;
    first_d      = first_q;
    left_d       = left_q;
    q_push_o     = 1'b0;
    for (int i = 0; i < HDR_LEN; i++) begin
      window_d[i] = window_q[i];
    end
    if (accept) begin
      if (in_payload_q) begin
        q_push_o = 1'b1;
        first_d  = 1'b0;
        left_d   = left_q - 1'b1;
        if (last_byte) begin
          in_payload_d = 1'b0;
          fill_d       = '0;
        end
      end else if (hdr_done && dims_ok) begin
        in_payload_d = 1'b1;
        first_d      = 1'b1;
        left_d       = prod_full[LEFT_W-1:0];
        fill_d       = '0;
      end else if (hdr_done || (fill_inc <= FILL_W'(MAGIC_LEN))) begin
        fill_d = scan_fill;
        for (int j = 0; j < SCAN_SPAN; j++) begin
          window_d[j] = shifted[j];
        end
      end else begin
        fill_d = fill_inc;
        for (int i = 0; i < HDR_LEN; i++) begin
          window_d[i] = app[i];
        end
      end
    end
  end

  assign q_entry_o.pixel = in_byte_i;
  assign q_entry_o.first = first_q;
  assign q_entry_o.last  = last_byte;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      in_payload_q <= 1'b0;
      first_q      <= 1'b0;
      left_q       <= '0;
    end else begin
      fill_q       <= fill_d;
      in_payload_q <= in_payload_d;
      first_q      <= first_d;
      left_q       <= left_d;
    end
  end

  // Header bytes, no reset
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < HDR_LEN; i++) begin
      window_q[i] <= window_d[i];
    end
  end

  `MHFD_ASSERT(a_fill_below_hdr, fill_q < FILL_W'(HDR_LEN), "header fill reached full length")
  `MHFD_ASSERT(a_payload_empty_win, !in_payload_q || (fill_q == '0 && left_q != '0),
               "payload state with held header bytes or no bytes left")
  `MHFD_ASSERT_NEXT(a_last_ends_frame, accept && in_payload_q && last_byte, !in_payload_q,
                    "frame did not end after last byte")

endmodule

`default_nettype wire

// ===== src/mhfd_queue.sv =====
// Short queue of payload requests between front and back.
// Depends on mhfd_pkg for depth and entry type.
`timescale 1ns / 1ps
`default_nettype none
`include "magic_header_frame_deframer_defines.svh"

module mhfd_queue import mhfd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire pix_entry_t entry_i,
  output      logic       ready_o,
  input  wire logic       pop_i,
  output      logic       valid_o,
  output      pix_entry_t entry_o
);

  pix_entry_t        mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign entry_o = mem_q[rd_ptr_q];

  // Store the pushed request
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= entry_i;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

  `MHFD_ASSERT(a_no_push_full, !push_i || ready_o, "push into a full queue")
  `MHFD_ASSERT_NEXT(a_count_up, do_push && !do_pop, count_q == $past(count_q) + 1'b1,
                    "occupancy did not grow on push")

endmodule

`default_nettype wire

// ===== src/mhfd_back.sv =====
// Back end: output register that drains the queue onto the result channel.
// Depends on mhfd_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none
`include "magic_header_frame_deframer_defines.svh"

module mhfd_back import mhfd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       q_valid_i,
  input  wire pix_entry_t q_entry_i,
  output      logic       q_pop_o,
  output      logic       out_valid_o,
  input  wire logic       out_ready_i,
  output      logic [7:0] pixel_byte_o,
  output      logic       frame_first_o,
  output      logic       frame_last_o
);

  logic       valid_q;
  pix_entry_t out_q;

  // Load a new request whenever the output slot is free or being taken
  assign q_pop_o = q_valid_i && (!valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_ready_i) begin
      valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) out_q <= q_entry_i;
  end

  assign out_valid_o   = valid_q;
  assign pixel_byte_o  = out_q.pixel;
  assign frame_first_o = out_q.first;
  assign frame_last_o  = out_q.last;

  `MHFD_ASSERT(a_no_pop_stalled, !(valid_q && !out_ready_i) || !q_pop_o,
               "queue popped while output stalled")

endmodule

`default_nettype wire

// ===== src/magic_header_frame_deframer.sv =====
// A payload byte passes through the queue and then the output register; header bytes
// give no result. Throughput: one byte per cycle, header and payload alike, while the
// queue has room; the magic compare at all offsets is parallel logic and a four-entry
// queue plus output register absorbs stalls. Reset (rst_ni low, asynchronous) empties
// the queue, clears the header hunt and loads magic 0, width 320 and height 240.
`timescale 1ns / 1ps
`default_nettype none

module magic_header_frame_deframer import mhfd_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire logic [7:0]            in_byte_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      logic [7:0]            pixel_byte_o,
  output      logic                  frame_first_o,
  output      logic                  frame_last_o
);

  logic       q_ready, q_push, q_valid, q_pop;
  pix_entry_t push_entry, head_entry;

  // Classify input bytes
  mhfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .q_ready_i  (q_ready),
    .q_push_o   (q_push),
    .q_entry_o  (push_entry)
  );

  // Decouple front and back
  mhfd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  // Drive the result channel
  mhfd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_entry_i     (head_entry),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_byte_o  (pixel_byte_o),
    .frame_first_o (frame_first_o),
    .frame_last_o  (frame_last_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/mhfd_frame_checker.sv =====
`timescale 1ns / 1ps
// Checker for the magic header frame deframer: watches the byte, pixel and register ports,
// tracks the header hunt on its own and compares every pixel request. Depends on mhfd_pkg.

module mhfd_frame_checker import mhfd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [7:0]            in_byte_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [7:0]            pixel_byte_i,
  input  logic                  frame_first_i,
  input  logic                  frame_last_i,
  output int unsigned           mismatches_o,
  output int unsigned           pending_o,
  output int unsigned           pixels_o,
  output int unsigned           frames_o
);

  typedef struct packed {
    logic [7:0] pixel;
    logic       first;
    logic       last;
  } pix_exp_t;

  // Register copies
  logic [31:0]       sync_word;
  logic [SIDE_W-1:0] cols_cfg;
  logic [SIDE_W-1:0] rows_cfg;

  // Hunt and payload state
  logic [7:0]        hdr_win [HDR_LEN];
  logic [FILL_W-1:0] hdr_fill;
  logic [LEFT_W-1:0] bytes_left;
  logic              in_frame;
  logic              first_due;

  pix_exp_t frame_pix_q [$];

  // Clamp a configured side into 1..MAX_SIDE
  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    if (v == '0) return SIDE_W'(1);
    if (v > SIDE_W'(MAX_SIDE)) return SIDE_W'(MAX_SIDE);
    return v;
  endfunction

  // Drop k bytes off the front of the header window
  function automatic void drop_front(input int k);
    int i;
    if (k >= int'(hdr_fill)) begin
      hdr_fill = '0;
      return;
    end
    for (i = 0; i < int'(hdr_fill) - k; i++) hdr_win[i] = hdr_win[i + k];
    hdr_fill = hdr_fill - FILL_W'(k);
  endfunction

  // Scan the held bytes for a magic prefix and, once full, a matching header
  function automatic void rescan_header();
    int                i;
    int                n;
    bit                ok;
    logic [31:0]       w_fld;
    logic [31:0]       h_fld;
    logic [SIDE_W-1:0] w_eff;
    logic [SIDE_W-1:0] h_eff;
    while (hdr_fill > 0) begin
      ok = 1'b1;
      n = (int'(hdr_fill) < MAGIC_LEN) ? int'(hdr_fill) : MAGIC_LEN;
      for (i = 0; i < n; i++) begin
        if (hdr_win[i] != sync_word[8*i +: 8]) ok = 1'b0;
      end
      if (!ok) begin
        drop_front(1);
        continue;
      end
      if (int'(hdr_fill) < HDR_LEN) return;
      w_eff = clamp_side(cols_cfg);
      h_eff = clamp_side(rows_cfg);
      w_fld = {hdr_win[7], hdr_win[6], hdr_win[5], hdr_win[4]};
      h_fld = {hdr_win[11], hdr_win[10], hdr_win[9], hdr_win[8]};
      if (w_fld != 32'(w_eff) || h_fld != 32'(h_eff)) begin
        drop_front(MAGIC_LEN);
        continue;
      end
      in_frame   = 1'b1;
      first_due  = 1'b1;
      bytes_left = LEFT_W'(w_eff) * LEFT_W'(h_eff);
      hdr_fill   = '0;
      return;
    end
  endfunction

  // Advance the hunt by one link byte; queue a pixel when inside a frame
  function automatic void take_byte(input logic [7:0] b);
    pix_exp_t e;
    if (in_frame) begin
      e.pixel   = b;
      e.first   = first_due;
      first_due = 1'b0;
      if (bytes_left > 0) bytes_left = bytes_left - 1'b1;
      if (bytes_left == 0) begin
        e.last   = 1'b1;
        in_frame = 1'b0;
        hdr_fill = '0;
      end else begin
        e.last = 1'b0;
      end
      frame_pix_q.push_back(e);
      return;
    end
    if (int'(hdr_fill) >= HDR_LEN) hdr_fill = '0;
    hdr_win[hdr_fill] = b;
    hdr_fill = hdr_fill + 1'b1;
    rescan_header();
  endfunction

  // Watch all ports at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    pix_exp_t e;
    pix_exp_t got;
    if (!rst_ni) begin
      sync_word  = '0;
      cols_cfg   = WIDTH_RST;
      rows_cfg   = HEIGHT_RST;
      hdr_fill   = '0;
      bytes_left = '0;
      in_frame   = 1'b0;
      first_due  = 1'b0;
      frame_pix_q.delete();
      mismatches_o = 0;
      pixels_o     = 0;
      frames_o     = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAGIC:  sync_word = cfg_data_i;
          CFG_WIDTH:  cols_cfg  = cfg_data_i[SIDE_W-1:0];
          CFG_HEIGHT: rows_cfg  = cfg_data_i[SIDE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got = '{pixel: pixel_byte_i, first: frame_first_i, last: frame_last_i};
        if (frame_pix_q.size() == 0) begin
          if (mismatches_o < 10)
            $display("%0t: unexpected pixel %h first %b last %b", $realtime,
                     got.pixel, got.first, got.last);
          mismatches_o++;
        end else begin
          e = frame_pix_q.pop_front();
          if (got != e) begin
            if (mismatches_o < 10)
              $display("%0t: pixel exp %h/%b/%b got %h/%b/%b (byte/first/last)",
                       $realtime, e.pixel, e.first, e.last, got.pixel, got.first, got.last);
            mismatches_o++;
          end
          pixels_o++;
          if (e.last) frames_o++;
        end
      end
      if (in_valid_i && in_ready_i) take_byte(in_byte_i);
    end
    pending_o = frame_pix_q.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Top of the deframer testbench: clock, reset, link byte stimulus, pixel sink and verdict.
// Depends on mhfd_pkg, magic_header_frame_deframer and mhfd_frame_checker.

module tb;
  import mhfd_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 6;
  localparam int RAND_BYTES    = 1400;
  localparam int PHASE_BYTES   = 200;
  localparam int PARTIAL_BYTES = 96;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  cfg_idx_e              cfg_idx = CFG_MAGIC;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_byte = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            pixel_byte;
  logic                  frame_first;
  logic                  frame_last;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned pixels;
  int unsigned frames;

  // Stimulus side view of the current setting, used to build headers
  logic [31:0]       cur_magic;
  logic [SIDE_W-1:0] cur_w;
  logic [SIDE_W-1:0] cur_h;

  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned bytes_sent = 0;
  int unsigned settings = 0;

  always #10 clk = ~clk;

  magic_header_frame_deframer i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .in_byte_i     (in_byte),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .pixel_byte_o  (pixel_byte),
    .frame_first_o (frame_first),
    .frame_last_o  (frame_last)
  );

  mhfd_frame_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_byte_i     (in_byte),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .pixel_byte_i  (pixel_byte),
    .frame_first_i (frame_first),
    .frame_last_i  (frame_last),
    .mismatches_o  (mismatches),
    .pending_o     (pending),
    .pixels_o      (pixels),
    .frames_o      (frames)
  );

  // Pixel sink: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      out_ready <= !idle_on || ($urandom_range(99) >= 31);
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [31:0] m, input logic [SIDE_W-1:0] w,
                            input logic [SIDE_W-1:0] h);
    cur_magic = m;
    cur_w     = w;
    cur_h     = h;
    write_reg(CFG_MAGIC, m);
    write_reg(CFG_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_HEIGHT, CFG_DATA_W'(h));
    settings++;
  endtask

  // Offer one byte, idling at random first, and hold it until accepted
  task automatic push_byte(input logic [7:0] b);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      in_byte  <= 8'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic push_word(input logic [31:0] w);
    int i;
    for (i = 0; i < 4; i++) push_byte(w[8*i +: 8]);
  endtask

  task automatic push_header(input logic [31:0] m, input logic [31:0] w, input logic [31:0] h);
    push_word(m);
    push_word(w);
    push_word(h);
  endtask

  task automatic push_random(input int n);
    int i;
    for (i = 0; i < n; i++) push_byte(8'($urandom));
  endtask

  // Wait until every pixel has come out, then let the pipeline settle
  task automatic drain();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_magic();
    logic [7:0] a;
    logic [7:0] c;
    a = 8'($urandom);
    c = 8'($urandom);
    case ($urandom_range(4))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return {4{a}};
      3:       return {c, a, c, a};
      default: return $urandom;
    endcase
  endfunction

  // One stretch of link traffic: noise, then a good, bad or cut header
  task automatic rand_frame();
    int          noise;
    int          kind;
    int          i;
    logic [31:0] wg;
    logic [31:0] hg;
    logic [31:0] bad;
    wg = (cur_w == 0) ? 32'd1 : 32'(cur_w);
    hg = (cur_h == 0) ? 32'd1 : 32'(cur_h);
    noise = $urandom_range(1) ? 0 : $urandom_range(1, 4);
    for (i = 0; i < noise; i++)
      push_byte($urandom_range(2) == 0 ? cur_magic[7:0] : 8'($urandom));
    kind = $urandom_range(99);
    if (kind < 70) begin
      push_header(cur_magic, wg, hg);
      push_random(wg * hg);
    end else if (kind < 78) begin
      // magic sits where the width goes: the rescan finds it after the drop
      push_word(cur_magic);
      push_header(cur_magic, wg, hg);
      push_random(wg * hg);
    end else if (kind < 88) begin
      bad = $urandom_range(1) ? 32'($urandom) : wg + $urandom_range(1, 3);
      if ($urandom_range(1)) push_header(cur_magic, bad, hg);
      else push_header(cur_magic, wg, bad);
      push_random($urandom_range(0, 4));
    end else if (kind < 95) begin
      bad = cur_magic ^ (32'($urandom_range(1, 255)) << (8 * $urandom_range(3)));
      push_header(bad, wg, hg);
      push_random(wg * hg);
    end else begin
      push_word(cur_magic);
      push_random($urandom_range(0, 7));
    end
  endtask

  initial begin
    int unsigned rand_start;
    int unsigned phase_start;
    int          phase;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: noise byte, one-byte frame, bad dimensions
    set_config(32'hFFFF_FFFF, SIDE_W'(1), SIDE_W'(1));
    push_byte(8'h12);
    push_header(32'hFFFF_FFFF, 1, 1);
    push_byte(8'h00);
    push_header(32'hFFFF_FFFF, 2, 1);
    drain();

    // Directed: change the setting in the middle of a 2x2 frame
    set_config(32'h0000_0000, SIDE_W'(2), SIDE_W'(2));
    push_header(32'h0000_0000, 2, 2);
    push_byte(8'h80);
    push_byte(8'h7F);
    drain();
    set_config(32'hC35A_3C96, SIDE_W'(1), SIDE_W'(1));
    push_byte(8'h01);
    push_byte(8'hFE);
    push_header(32'hC35A_3C96, 1, 1);
    push_byte(8'h55);
    drain();

    // Random phases with fresh settings, one long run without idling
    rand_start = bytes_sent;
    phase = 0;
    while (bytes_sent - rand_start < RAND_BYTES) begin
      if (phase == 0) begin
        set_config($urandom, SIDE_W'(8), SIDE_W'(8));
        hold_req = 1'b1;
      end else if ($urandom_range(7) == 0) begin
        set_config(pick_magic(), SIDE_W'($urandom_range(12, 16)), SIDE_W'($urandom_range(0, 3)));
      end else begin
        set_config(pick_magic(), SIDE_W'($urandom_range(0, 10)), SIDE_W'($urandom_range(0, 6)));
      end
      idle_on = (phase != 2);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) rand_frame();
      drain();
      phase++;
    end
    idle_on = 1'b1;

    // Directed: zero width counts as one, oversize height as MAX_SIDE; leave the frame open
    set_config(32'h9E01_7F80, SIDE_W'(0), 13'h1FFF);
    push_header(32'h9E01_7F80, 1, MAX_SIDE);
    push_random(PARTIAL_BYTES);
    drain();

    $display("Run sent %0d link bytes under %0d register settings, one long sink hold-off.",
             bytes_sent, settings);
    $display("Compared %0d pixels in %0d complete frames.", pixels, frames);
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
